// ===== hw/rtl/tcws_pkg.sv =====
// Package: types and constants shared by the text console writer.
`default_nettype none
package tcws_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int LAST_BASE  = CELL_COUNT - COLUMNS;

	localparam int IDX_W  = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
	localparam logic [7:0]        SPACE_CODE   = 8'h20;
	localparam logic [7:0]        NULL_CODE    = 8'h00;
	localparam logic [CELL_W-1:0] ATTR_MASK    = 16'hFF00;

	typedef struct packed {
		logic [1:0]        mode;
		logic [7:0]        char_code;
		logic [IDX_W-1:0]  cell_index;
		logic [CELL_W-1:0] cell_value;
	} tcws_req_t;

	typedef struct packed {
		logic [CELL_W-1:0] read_value;
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row;
		logic              did_scroll;
	} tcws_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_DRAIN,
		ST_FINISH
	} tcws_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/text_console_writer_scroll.sv =====
// Top level: text console screen memory with cursor, put-character and scroll.
`default_nettype none
// Text console writer: an 80x25 screen of 16-bit cells in one on-chip memory with a
// registered read. After reset the block sweeps the memory to zero, one cell per
// cycle, and accepts no transaction until that pass is done. For an item, the accept
// cycle issues the memory read and the next cycle writes the cell back and updates the
// cursor; the next item is accepted as the result is loaded into the output register.
// A put that moves past the last row scrolls the screen by copying each cell through
// the same read and write ports, one cell per cycle. A result waits in the output
// register while the following item is already accepted.
module text_console_writer_scroll
	import tcws_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire tcws_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output tcws_rsp_t      rsp
);

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;

	tcws_state_t state_q, state_d;
	logic [IDX_W-1:0] ptr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	tcws_req_t        item_q;
	logic [IDX_W-1:0] cur_addr_q;
	tcws_rsp_t        res_q;
	tcws_rsp_t        out_q;
	logic             out_valid_q;

	logic             vld_s1;
	logic [IDX_W-1:0] tgt_s1;
	logic             last_s1;

	logic              accept;
	logic              out_free;
	logic              load_out;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic [IDX_W-1:0]  mem_ra;
	logic [IDX_W-1:0]  cur_addr;
	logic [IDX_W-1:0]  scroll_src;

	// execute-stage results
	logic [COL_W:0]   col_nx;
	logic [ROW_W:0]   row_nx;
	logic             put_we;
	logic             raw_we;
	logic             do_scroll;
	logic [CELL_W-1:0] rd_val;

	assign cur_addr   = IDX_W'(row_q) * IDX_W'(COLUMNS) + IDX_W'(col_q);
	assign scroll_src = (ptr_q < IDX_W'(LAST_BASE)) ? ptr_q + IDX_W'(COLUMNS) : ptr_q;
	assign out_free   = !out_valid_q || rsp_ready;
	assign accept     = req_valid && req_ready;

	always_comb begin
		col_nx    = {1'b0, col_q};
		row_nx    = {1'b0, row_q};
		put_we    = 1'b0;
		raw_we    = 1'b0;
		do_scroll = 1'b0;
		rd_val    = '0;
		case (item_q.mode)
			MODE_PUT: begin
				if (item_q.char_code == NEWLINE_CODE) begin
					col_nx = '0;
					row_nx = row_nx + 1'b1;
				end else if (item_q.char_code != NULL_CODE) begin
					put_we = 1'b1;
					col_nx = col_nx + 1'b1;
				end
				if (col_nx >= (COL_W+1)'(COLUMNS)) begin
					col_nx = '0;
					row_nx = row_nx + 1'b1;
				end
				if (row_nx >= (ROW_W+1)'(ROWS)) begin
					do_scroll = 1'b1;
					col_nx    = '0;
					row_nx    = (ROW_W+1)'(ROWS - 1);
				end
			end
			MODE_READ: begin
				if (item_q.cell_index < IDX_W'(CELL_COUNT))
					rd_val = rdata_q;
			end
			MODE_WRITE: begin
				raw_we = item_q.cell_index < IDX_W'(CELL_COUNT);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		load_out  = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = ptr_q;
		mem_wd    = '0;
		mem_ra    = cur_addr;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (ptr_q == IDX_W'(CELL_COUNT - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_EXEC: begin
				if (put_we) begin
					mem_we = 1'b1;
					mem_wa = cur_addr_q;
					mem_wd = {rdata_q[CELL_W-1:8], item_q.char_code};
				end else if (raw_we) begin
					mem_we = 1'b1;
					mem_wa = item_q.cell_index;
					mem_wd = item_q.cell_value;
				end
				state_d = do_scroll ? ST_SCROLL : ST_FINISH;
			end
			ST_SCROLL: begin
				mem_ra = scroll_src;
				if (ptr_q == IDX_W'(CELL_COUNT - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out  = 1'b1;
					req_ready = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (req_ready) begin
			if (req.mode == MODE_READ && req.cell_index < IDX_W'(CELL_COUNT))
				mem_ra = req.cell_index;
			if (req_valid)
				state_d = ST_EXEC;
		end
		// copy pipeline write-back during the scroll sweep
		if (vld_s1) begin
			mem_we = 1'b1;
			mem_wa = tgt_s1;
			mem_wd = last_s1 ? ((rdata_q & ATTR_MASK) | CELL_W'(SPACE_CODE)) : rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR || state_q == ST_SCROLL)
				ptr_q <= (ptr_q == IDX_W'(CELL_COUNT - 1)) ? '0 : ptr_q + 1'b1;
			if (state_q == ST_EXEC) begin
				col_q <= col_nx[COL_W-1:0];
				row_q <= row_nx[ROW_W-1:0];
			end
			vld_s1 <= (state_q == ST_SCROLL);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		tgt_s1  <= ptr_q;
		last_s1 <= ptr_q >= IDX_W'(LAST_BASE);
		if (accept) begin
			item_q     <= req;
			cur_addr_q <= cur_addr;
		end
		if (state_q == ST_EXEC) begin
			res_q.read_value    <= rd_val;
			res_q.cursor_column <= col_nx[COL_W-1:0];
			res_q.cursor_row    <= row_nx[ROW_W-1:0];
			res_q.did_scroll    <= do_scroll;
		end
		if (load_out)
			out_q <= res_q;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < COL_W'(COLUMNS) && row_q < ROW_W'(ROWS))
		else $error("cursor out of screen");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted transaction not executed");

	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCROLL || state_q == ST_DRAIN))
		else $error("scroll write-back outside scroll sweep");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.did_scroll |->
			out_q.cursor_column == '0 && out_q.cursor_row == ROW_W'(ROWS - 1))
		else $error("scroll result with wrong cursor");
`endif

endmodule
`default_nettype wire
